>>> rtl/pjw_string_hash_mod_macros.svh
// ----------------------------------------------------------------------------
// pjw_string_hash_mod_macros.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef PJW_STRING_HASH_MOD_MACROS_SVH
`define PJW_STRING_HASH_MOD_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PJW_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pjw hash check failed");

// antecedent implies consequent in the following cycle
`define PJW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pjw hash check failed");

`endif

>>> rtl/pjwhash_pkg.sv
// ----------------------------------------------------------------------------
// pjwhash_pkg
// shared widths, register indexes, types and the pjw character update
// ----------------------------------------------------------------------------
package pjwhash_pkg;

    localparam int CHAR_W     = 8;
    localparam int HASH_W     = 32;
    localparam int RADIX_SH   = 6;
    localparam int WIDE_W     = HASH_W + RADIX_SH;
    localparam int CNT_W      = $clog2(WIDE_W + 1);
    localparam int FOLD_SHIFT = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [HASH_W-1:0] TOP_NIBBLE_MASK = 32'hF000_0000;
    localparam logic [HASH_W-1:0] MODULUS_RESET   = 32'd104729;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_MODULUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_MODE     = 2'd1;

    // request into the serial modulo unit
    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] dividend;
    } red_req_t;

    // status back from the serial modulo unit
    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] remainder;
    } red_stat_t;

    // shift by one nibble, add the character, fold the top nibble back in
    function automatic logic [HASH_W-1:0] pjw_update(
        input logic [HASH_W-1:0] h,
        input logic [CHAR_W-1:0] c
    );
        logic [HASH_W-1:0] s;
        logic [HASH_W-1:0] g;
        s = (h << 4) + {{(HASH_W-CHAR_W){1'b0}}, c};
        g = s & TOP_NIBBLE_MASK;
        return s ^ (g >> FOLD_SHIFT) ^ g;
    endfunction

endpackage

>>> rtl/pjwhash_char_if.sv
// ----------------------------------------------------------------------------
// pjwhash_char_if
// valid/ready channel carrying one key character per request
// ----------------------------------------------------------------------------
interface pjwhash_char_if;

    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);

endinterface

>>> rtl/pjwhash_bucket_if.sv
// ----------------------------------------------------------------------------
// pjwhash_bucket_if
// valid/ready channel carrying one hash bucket per request
// ----------------------------------------------------------------------------
interface pjwhash_bucket_if;

    logic        valid;
    logic        ready;
    logic [31:0] bucket;

    modport source (output valid, output bucket, input ready);
    modport sink   (input valid, input bucket, output ready);

endinterface

>>> rtl/pjwhash_mod_unit.sv
// ----------------------------------------------------------------------------
// pjwhash_mod_unit
// bit-serial restoring modulo: one dividend bit per cycle, msb first
// ----------------------------------------------------------------------------
module pjwhash_mod_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pjwhash_pkg::red_req_t               req,
    input  logic [pjwhash_pkg::HASH_W-1:0]      modulus,
    output pjwhash_pkg::red_stat_t              stat
);
    import pjwhash_pkg::*;

    logic [WIDE_W-1:0] div_reg;
    logic [WIDE_W-1:0] div_next;
    logic [HASH_W-1:0] rem_reg;
    logic [HASH_W-1:0] rem_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [HASH_W:0]   trial;
    logic [HASH_W-1:0] diff;

    // one compare and subtract step; the difference fits when trial >= modulus
    assign trial = {rem_reg, div_reg[WIDE_W-1]};
    assign diff  = trial[HASH_W-1:0] - modulus;

    always_comb
    begin
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            div_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(WIDE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            div_next = {div_reg[WIDE_W-2:0], 1'b0};
            if (trial >= {1'b0, modulus})
            begin
                rem_next = diff;
            end
            else
            begin
                rem_next = trial[HASH_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

endmodule

>>> rtl/pjw_string_hash_mod.sv
// PJW nibble-fold hash accepts characters back to back.
// Radix-64 polynomial characters with a nonzero modulus go through a load,
// 38 steps of the bit-serial modulo unit and a writeback.
// A terminator goes to the output register via the deliver state, after the
// same modulo unit when the PJW hash is reduced; the result then waits there.
// Reset clears control, the accumulator, and restores modulus 104729, PJW mode.
// ----------------------------------------------------------------------------
// pjw_string_hash_mod
// per-character string hash with bucket reduction by the table size
// ----------------------------------------------------------------------------
module pjw_string_hash_mod
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    pjwhash_char_if.sink                         char_stream,
    pjwhash_bucket_if.source                     bucket_stream,
    input  logic                                 cfg_wr_en,
    input  logic [pjwhash_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pjwhash_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pjwhash_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_RED     = 2'd1;
    localparam logic [1:0] ST_DELIVER = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [HASH_W-1:0] modulus_reg;
    logic              poly_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] res_reg;
    logic [HASH_W-1:0] res_next;
    logic              op_poly_reg;
    logic              op_poly_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [HASH_W-1:0] out_bucket_reg;
    logic [HASH_W-1:0] out_bucket_next;

    logic              in_fire;
    logic              is_term;
    logic              mod_zero;
    logic [WIDE_W-1:0] poly_wide;
    red_req_t          red_req;
    red_stat_t         red_stat;

    assign char_stream.ready = (state_reg == ST_IDLE);
    assign in_fire   = char_stream.valid && char_stream.ready;
    assign is_term   = (char_stream.char_code == '0);
    assign mod_zero  = (modulus_reg == '0);
    assign poly_wide = {hash_reg, {RADIX_SH{1'b0}}}
                     + {{(WIDE_W-CHAR_W){1'b0}}, char_stream.char_code};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            poly_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_TABLE_MODULUS)
            begin
                modulus_reg <= cfg_data[HASH_W-1:0];
            end
            else if (cfg_index == REG_POLY_MODE)
            begin
                poly_reg <= cfg_data[0];
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        hash_next        = hash_reg;
        res_next         = res_reg;
        op_poly_next     = op_poly_reg;
        out_valid_next   = out_valid_reg;
        out_bucket_next  = out_bucket_reg;
        red_req.start    = 1'b0;
        red_req.dividend = poly_wide;

        // output register drains independently
        if (out_valid_reg && bucket_stream.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_poly_next = poly_reg;
                    if (!is_term)
                    begin
                        if (!poly_reg)
                        begin
                            hash_next = pjw_update(hash_reg, char_stream.char_code);
                        end
                        else if (mod_zero)
                        begin
                            hash_next = poly_wide[HASH_W-1:0];
                        end
                        else
                        begin
                            red_req.start = 1'b1;
                            state_next    = ST_RED;
                        end
                    end
                    else
                    begin
                        hash_next = '0;
                        if (!poly_reg && !mod_zero)
                        begin
                            red_req.start    = 1'b1;
                            red_req.dividend = {{RADIX_SH{1'b0}}, hash_reg};
                            state_next       = ST_RED;
                        end
                        else
                        begin
                            res_next   = hash_reg;
                            state_next = ST_DELIVER;
                        end
                    end
                end
            end
            ST_RED:
            begin
                if (red_stat.done)
                begin
                    if (op_poly_reg)
                    begin
                        hash_next  = red_stat.remainder;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        res_next   = red_stat.remainder;
                        state_next = ST_DELIVER;
                    end
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || bucket_stream.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_bucket_next = res_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= '0;
            op_poly_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            op_poly_reg   <= op_poly_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        out_bucket_reg <= out_bucket_next;
    end

    // serial modulo unit
    pjwhash_mod_unit u_mod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (red_req),
        .modulus (modulus_reg),
        .stat    (red_stat)
    );

    assign bucket_stream.valid  = out_valid_reg;
    assign bucket_stream.bucket = out_bucket_reg;

endmodule

>>> rtl/pjwhash_checker.sv
// ----------------------------------------------------------------------------
// pjwhash_checker
// port-level checks on the hash block, bound to the top level
// ----------------------------------------------------------------------------
`include "pjw_string_hash_mod_macros.svh"

module pjwhash_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  in_char,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_bucket
);

    // a stalled result stays offered
    `PJW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bucket))

    // a character request never produces a result on its own
    `PJW_ASSERT_NEXT(a_char_no_result, in_valid && in_ready && in_char != 8'd0 && !out_valid, !out_valid)

    // a terminator blocks the input while its result is formed
    `PJW_ASSERT_NEXT(a_term_busy, in_valid && in_ready && in_char == 8'd0, !in_ready)

    // a new result only appears after the input side went quiet
    `PJW_ASSERT_SAME(a_result_source, $rose(out_valid), !$past(in_ready))

endmodule

bind pjw_string_hash_mod pjwhash_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (char_stream.valid),
    .in_ready   (char_stream.ready),
    .in_char    (char_stream.char_code),
    .out_valid  (bucket_stream.valid),
    .out_ready  (bucket_stream.ready),
    .out_bucket (bucket_stream.bucket)
);
